// File: hdl/mqg_pkg.sv
// Shared types and constants for the mouse quadrature generator.
// No dependencies; used by mqg_core and mouse_quadrature_generator.
`default_nettype none

package mqg_pkg;

	localparam int PeriodWidth  = 24;
	localparam int DeltaWidth   = 16;
	localparam int PendWidth    = 17;
	localparam int InDataWidth  = 40;
	localparam int OutDataWidth = 8;

	localparam logic [PeriodWidth-1:0] PERIOD_RESET = 24'd22727;

	// quadrature tables, bit i is the level at phase i
	localparam logic [3:0] PHASE_TAB_A = 4'b0011;
	localparam logic [3:0] PHASE_TAB_B = 4'b0110;

	// button bit positions
	localparam int BTN_LEFT   = 0;
	localparam int BTN_RIGHT  = 1;
	localparam int BTN_MIDDLE = 2;

	// action codes
	localparam logic ACT_EVENT = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	typedef struct packed {
		logic                          action;
		logic [2:0]                    buttons;
		logic signed [DeltaWidth-1:0]  delta_x;
		logic signed [DeltaWidth-1:0]  delta_y;
	} in_item_t;

	// packed MSB first, so horiz_a lands in bit 0
	typedef struct packed {
		logic busy_res;
		logic middle_n;
		logic right_n;
		logic left_n;
		logic vert_b;
		logic vert_a;
		logic horiz_b;
		logic horiz_a;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/mqg_core.sv
// Motion state of the generator: pending counts, phases, step timer, buttons.
// Depends on mqg_pkg. Updates state on step_en and presents the result word.
`default_nettype none

module mqg_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 step_en,
	input  wire  mqg_pkg::in_item_t             item,
	input  wire  [mqg_pkg::PeriodWidth-1:0]     period,
	output mqg_pkg::result_t                    result
);

	typedef struct packed {
		logic [1:0]                             phase;
		logic signed [mqg_pkg::PendWidth-1:0]   pend;
	} axis_t;

	axis_t                          horiz_q, vert_q, horiz_d, vert_d;
	logic [mqg_pkg::PeriodWidth-1:0] timer_q, timer_d;
	logic [2:0]                     buttons_q, buttons_d;

	function automatic logic signed [mqg_pkg::PendWidth-1:0] sat_add(
		input logic signed [mqg_pkg::PendWidth-1:0]  acc,
		input logic signed [mqg_pkg::DeltaWidth-1:0] d
	);
		logic signed [mqg_pkg::PendWidth:0] sum;
		sum = {acc[mqg_pkg::PendWidth-1], acc}
			+ {{(mqg_pkg::PendWidth+1-mqg_pkg::DeltaWidth){d[mqg_pkg::DeltaWidth-1]}}, d};
		if (sum > 18'sd65535)
			return 17'sh0FFFF;
		else if (sum < -18'sd65536)
			return 17'sh10000;
		else
			return sum[mqg_pkg::PendWidth-1:0];
	endfunction

	// one step toward zero; phase follows the sign
	function automatic axis_t step_axis(input axis_t a);
		axis_t r;
		r = a;
		if (a.pend > 0) begin
			r.phase = a.phase + 2'd1;
			r.pend  = a.pend - 17'sd1;
		end else if (a.pend < 0) begin
			r.phase = a.phase - 2'd1;
			r.pend  = a.pend + 17'sd1;
		end
		return r;
	endfunction

	always_comb begin
		horiz_d   = horiz_q;
		vert_d    = vert_q;
		timer_d   = timer_q;
		buttons_d = buttons_q;
		if (step_en) begin
			if (item.action == mqg_pkg::ACT_EVENT) begin
				buttons_d    = ~item.buttons;
				horiz_d.pend = sat_add(horiz_q.pend, item.delta_x);
				vert_d.pend  = sat_add(vert_q.pend, item.delta_y);
			end else if (timer_q <= 24'd1) begin
				horiz_d = step_axis(horiz_q);
				vert_d  = step_axis(vert_q);
				timer_d = period;
			end else begin
				timer_d = timer_q - 24'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horiz_q   <= '0;
			vert_q    <= '0;
			timer_q   <= '0;
			buttons_q <= 3'b111;
		end else begin
			horiz_q   <= horiz_d;
			vert_q    <= vert_d;
			timer_q   <= timer_d;
			buttons_q <= buttons_d;
		end
	end

	always_comb begin
		result.horiz_a  = mqg_pkg::PHASE_TAB_A[horiz_d.phase];
		result.horiz_b  = mqg_pkg::PHASE_TAB_B[horiz_d.phase];
		result.vert_a   = mqg_pkg::PHASE_TAB_A[vert_d.phase];
		result.vert_b   = mqg_pkg::PHASE_TAB_B[vert_d.phase];
		result.left_n   = buttons_d[mqg_pkg::BTN_LEFT];
		result.right_n  = buttons_d[mqg_pkg::BTN_RIGHT];
		result.middle_n = buttons_d[mqg_pkg::BTN_MIDDLE];
		result.busy_res = (horiz_d.pend != '0) || (vert_d.pend != '0);
	end

endmodule

`default_nettype wire

// File: hdl/mouse_quadrature_generator.sv
// Top level of the mouse quadrature generator: stream ports, input and result
// registers, period register. Depends on mqg_pkg and mqg_core.
`default_nettype none

// Each input word is either a mouse event (tuser = 0: buttons and signed
// deltas added to saturating 17-bit pending counts) or a timing tick
// (tuser = 1). Every word yields exactly one result word holding the quadrature
// pin levels, the active-low button lines and a busy flag. One word is taken
// per clock unless the output stalls; each word passes from the input register
// through the state update into the result register. Ticks count down the step
// timer, which reloads from the period register on expiry, so each axis with a
// nonzero pending count steps once every period ticks.
module mouse_quadrature_generator (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [mqg_pkg::PeriodWidth-1:0]     cfg_data,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// buttons[2:0], delta_x[18:3], delta_y[34:19], zero pad[39:35]
	input  wire  [mqg_pkg::InDataWidth-1:0]     s_axis_tdata,
	// action[0]
	input  wire                                 s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// horiz_a, horiz_b, vert_a, vert_b, left_n, right_n, middle_n, busy_res
	output logic [mqg_pkg::OutDataWidth-1:0]    m_axis_tdata
);

	logic [mqg_pkg::PeriodWidth-1:0] period_q;
	logic                            valid_s1;
	mqg_pkg::in_item_t               item_s1;
	logic                            valid_s2;
	mqg_pkg::result_t                result_s2;
	mqg_pkg::result_t                core_result;
	logic                            advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= mqg_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.action  <= s_axis_tuser;
			item_s1.buttons <= s_axis_tdata[2:0];
			item_s1.delta_x <= s_axis_tdata[18:3];
			item_s1.delta_y <= s_axis_tdata[34:19];
		end
	end

	mqg_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.item        (item_s1),
		.period      (period_q),
		.result      (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// Stream-level testbench for mouse_quadrature_generator: random gaps and stalls,
// a cycle-free predictor of the pin levels, and a scoreboard. Depends on mqg_pkg.

module tb;

	localparam int IdleLimit = 2000;

	logic                             clk           = 1'b0;
	logic                             arst_n        = 1'b0;
	logic                             cfg_we        = 1'b0;
	logic [mqg_pkg::PeriodWidth-1:0]  cfg_data      = '0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [mqg_pkg::InDataWidth-1:0]  s_axis_tdata  = '0;
	logic                             s_axis_tuser  = 1'b0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [mqg_pkg::OutDataWidth-1:0] m_axis_tdata;

	// predicted block state
	logic [mqg_pkg::PeriodWidth-1:0]  period_reg;
	logic [mqg_pkg::PeriodWidth-1:0]  step_timer;
	logic [1:0]              horiz_ph;
	logic [1:0]              vert_ph;
	int                      horiz_pend;
	int                      vert_pend;
	logic [2:0]              btn_lines;

	mqg_pkg::result_t pin_levels_q[$];

	int  bad_fields  = 0;
	int  words_sent  = 0;
	int  steps_taken = 0;
	int  sat_hits    = 0;
	int  idle_cycles = 0;
	int  stall_left  = 0;
	bit  quiet       = 1'b0;

	string field_names[mqg_pkg::OutDataWidth] = '{"horiz_a", "horiz_b", "vert_a", "vert_b",
		"left_n", "right_n", "middle_n", "busy_res"};

	mouse_quadrature_generator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int clamp_pending(int s);
		if (s > 65535) begin
			sat_hits++;
			return 65535;
		end
		if (s < -65536) begin
			sat_hits++;
			return -65536;
		end
		return s;
	endfunction

	task automatic step_axis(inout logic [1:0] ph, inout int pend);
		if (pend > 0) begin
			ph = ph + 2'd1;
			pend--;
		end else if (pend < 0) begin
			ph = ph - 2'd1;
			pend++;
		end
	endtask

	// update the predicted state for one accepted word, queue the pin levels
	task automatic advance_mouse(input mqg_pkg::in_item_t w);
		mqg_pkg::result_t r;
		if (w.action == mqg_pkg::ACT_EVENT) begin
			btn_lines  = ~w.buttons;
			horiz_pend = clamp_pending(horiz_pend + int'(w.delta_x));
			vert_pend  = clamp_pending(vert_pend + int'(w.delta_y));
		end else if (step_timer <= 1) begin
			if (horiz_pend != 0 || vert_pend != 0)
				steps_taken++;
			step_axis(horiz_ph, horiz_pend);
			step_axis(vert_ph, vert_pend);
			step_timer = period_reg;
		end else begin
			step_timer = step_timer - 24'd1;
		end
		// A follows 1,1,0,0 and B follows 0,1,1,0 over the phase
		r.horiz_a  = ~horiz_ph[1];
		r.horiz_b  = horiz_ph[1] ^ horiz_ph[0];
		r.vert_a   = ~vert_ph[1];
		r.vert_b   = vert_ph[1] ^ vert_ph[0];
		r.left_n   = btn_lines[mqg_pkg::BTN_LEFT];
		r.right_n  = btn_lines[mqg_pkg::BTN_RIGHT];
		r.middle_n = btn_lines[mqg_pkg::BTN_MIDDLE];
		r.busy_res = (horiz_pend != 0 || vert_pend != 0);
		pin_levels_q.push_back(r);
	endtask

	task automatic send_word(input mqg_pkg::in_item_t w);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= w.action;
		s_axis_tdata  <= {5'b0, w.delta_y, w.delta_x, w.buttons};
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
		advance_mouse(w);
	endtask

	task automatic send_event(input logic [2:0] btn, input int dx, input int dy);
		mqg_pkg::in_item_t w;
		w.action  = mqg_pkg::ACT_EVENT;
		w.buttons = btn;
		w.delta_x = dx[15:0];
		w.delta_y = dy[15:0];
		send_word(w);
	endtask

	// junk in the event fields must be ignored on a tick
	task automatic send_tick();
		mqg_pkg::in_item_t w;
		w.action  = mqg_pkg::ACT_TICK;
		w.buttons = 3'($urandom);
		w.delta_x = 16'($urandom);
		w.delta_y = 16'($urandom);
		send_word(w);
	endtask

	// only write while the block is drained
	task automatic set_period(input logic [mqg_pkg::PeriodWidth-1:0] p);
		s_axis_tvalid <= 1'b0;
		while (pin_levels_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= p;
		@(posedge clk);
		cfg_we     <= 1'b0;
		period_reg = p;
	endtask

	function automatic int pick_delta(int pend);
		int r;
		int want;
		r = $urandom_range(0, 99);
		if (r < 80)
			return int'($urandom_range(0, 6)) - 3;
		if (r < 90) begin
			want = $urandom;
			return int'($signed(want[15:0]));
		end
		// cancel what is pending, as far as one word allows
		want = -pend;
		if (want > 32767)
			want = 32767;
		if (want < -32768)
			want = -32768;
		return want;
	endfunction

	task automatic test_directed();
		// short period first so the first reload keeps the timer small
		set_period(24'd1);
		// first tick after reset expires at once, nothing pending
		send_tick();
		send_event(3'b000, 0, 0);
		send_event(3'b001, 0, 0);
		send_event(3'b010, 0, 0);
		send_event(3'b100, 0, 0);
		send_event(3'b111, 0, 0);
		// positive count steps up, negative steps down, busy drops at zero
		send_event(3'b000, 2, -2);
		send_tick();
		send_tick();
		send_tick();
		// saturate both axes at opposite ends
		send_event(3'b101, 32767, -32768);
		send_event(3'b101, 32767, -32768);
		send_event(3'b101, 32767, -32768);
		send_tick();
		send_event(3'b010, -32768, 32767);
		send_event(3'b010, -32768, 32767);
		send_tick();
		send_tick();
		send_tick();
		// zero period acts as one
		set_period(24'd0);
		send_event(3'b000, 1, -1);
		send_tick();
		send_tick();
		send_tick();
	endtask

	task automatic test_random(input logic [mqg_pkg::PeriodWidth-1:0] p, input int count);
		set_period(p);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 65)
				send_tick();
			else
				send_event(3'($urandom), pick_delta(horiz_pend), pick_delta(vert_pend));
		end
		quiet = 1'b0;
	endtask

	// receiver stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			stall_left    <= pick_gap();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		mqg_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pin_levels_q.size() == 0) begin
				bad_fields++;
				$display("%t: unexpected word, actual %b", $time, m_axis_tdata);
			end else begin
				want = pin_levels_q.pop_front();
				for (int i = 0; i < mqg_pkg::OutDataWidth; i++)
					if (m_axis_tdata[i] !== want[i]) begin
						bad_fields++;
						$display("%t: %s expected %b actual %b", $time, field_names[i],
							want[i], m_axis_tdata[i]);
					end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("%t: no word moved for %0d cycles", $time, IdleLimit);
				$display("mouse_quadrature_generator: mismatch");
				$finish;
			end
		end
	end

	initial begin
		period_reg = mqg_pkg::PERIOD_RESET;
		step_timer = '0;
		horiz_ph   = '0;
		vert_ph    = '0;
		horiz_pend = 0;
		vert_pend  = 0;
		btn_lines  = 3'b111;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(24'd1, 300);
		test_random(24'd2, 250);
		test_random(24'd3, 200);
		test_random(24'($urandom_range(4, 9)), 250);
		test_random(24'd0, 150);
		test_random(24'($urandom_range(1, 5)), 150);
		test_random(24'hFFFFFF, 100);

		s_axis_tvalid <= 1'b0;
		while (pin_levels_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d words over periods 0, 1, 2, 3, small random and 24'hFFFFFF",
			words_sent);
		$display("%0d timer expiries moved the pins, %0d pending sums saturated",
			steps_taken, sat_hits);
		if (bad_fields == 0)
			$display("mouse_quadrature_generator: match");
		else
			$display("mouse_quadrature_generator: mismatch");
		$finish;
	end

endmodule
